>>> rtl/core/ptcg_pkg.sv
package ptcg_pkg;

    localparam int CoordW   = 32;
    localparam int TexW     = 17;
    localparam int FracW    = 16;
    localparam int TolW     = 16;
    localparam int DivSteps = FracW;

    localparam logic [TexW-1:0] TexZero = TexW'(0);
    localparam logic [TexW-1:0] TexHalf = TexW'(32768);
    localparam logic [TexW-1:0] TexOne  = TexW'(65536);
    localparam logic [TolW-1:0] TolReset = TolW'(7);

    typedef logic signed [CoordW-1:0] t_coord;

    typedef enum logic [1:0] {
        PLANE_XY = 2'd0,
        PLANE_YZ = 2'd1,
        PLANE_XZ = 2'd2
    } t_plane;

    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_Y = 3'd2,
        CFG_MAX_Y = 3'd3,
        CFG_MIN_Z = 3'd4,
        CFG_MAX_Z = 3'd5,
        CFG_TOL   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vert;

    typedef struct packed {
        t_vert [2:0] vert;
        t_plane      plane;
    } t_tri;

    typedef struct packed {
        t_coord [2:0]    lo;
        t_coord [2:0]    hi;
        logic [TolW-1:0] tol;
    } t_cfg;

    typedef struct packed {
        logic              spec;
        logic [TexW-1:0]   spec_val;
        logic [CoordW-1:0] rem;
        logic [CoordW-1:0] den;
        logic [FracW-1:0]  quo;
    } t_lane;

    typedef struct packed {
        t_plane     plane;
        logic [1:0] slot;
        logic       last;
    } t_side;

endpackage

>>> rtl/core/planar_texture_coord_gen_unit.sv
// Planar texture projection of triangles.
// Input channel: one triangle per transaction (i_a_* .. i_c_*, signed Q16.16),
// taken when i_valid is high and o_stall is low. The triangle is classified
// on entry (plane choice by tolerance) and placed in a two-entry queue.
// Output channel: three transactions per triangle, vertex a, b, c in order,
// with o_last on the third; taken when o_valid is high and i_stall is low.
// Configuration: i_cfg_index selects min_x, max_x, min_y, max_y, min_z, max_z
// or tolerance; o_cfg_ready is always high. Write only while the block is idle.
// Path: an accepted triangle is registered in the queue, then its vertices pass
// in order through the back stages (differences, then case sorting) and the divider.
// Throughput: one result per cycle while i_stall is low, set by the single
// result channel; two 16-stage pipelined dividers (u and v) keep up.
// A stalled output freezes the whole back pipeline; the queue then fills and
// o_stall rises. Reset clears all valid state and sets the box to zero and the
// tolerance to 7.
module planar_texture_coord_gen_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_c_x,
    input  logic signed [31:0] i_c_y,
    input  logic signed [31:0] i_c_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_tex_u,
    output logic [16:0] o_tex_v,
    output logic [1:0]  o_plane,
    output logic [1:0]  o_vertex_slot,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ptcg_pkg::*;

    t_cfg  r_cfg;
    t_vert [2:0] in_vert;
    logic  q_full, q_empty, push, pop, en;
    t_tri  push_tri, head;
    logic  bk_valid;
    t_side bk_side, out_side;
    t_lane bk_u, bk_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo  <= '0;
            r_cfg.hi  <= '0;
            r_cfg.tol <= TolReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_X: r_cfg.lo[0] <= i_cfg_data;
                CFG_MAX_X: r_cfg.hi[0] <= i_cfg_data;
                CFG_MIN_Y: r_cfg.lo[1] <= i_cfg_data;
                CFG_MAX_Y: r_cfg.hi[1] <= i_cfg_data;
                CFG_MIN_Z: r_cfg.lo[2] <= i_cfg_data;
                CFG_MAX_Z: r_cfg.hi[2] <= i_cfg_data;
                CFG_TOL:   r_cfg.tol   <= i_cfg_data[TolW-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        in_vert[0] = '{x: i_a_x, y: i_a_y, z: i_a_z};
        in_vert[1] = '{x: i_b_x, y: i_b_y, z: i_b_z};
        in_vert[2] = '{x: i_c_x, y: i_c_y, z: i_c_z};
    end

    // The back pipeline moves only when the output register can be refilled.
    assign en = !(o_valid && i_stall);

    ptcg_front u_front (
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_vert     (in_vert),
        .i_tol      (r_cfg.tol),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_tri (push_tri)
    );

    ptcg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_tri (push_tri),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_head     (head)
    );

    ptcg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_empty  (q_empty),
        .i_head   (head),
        .i_cfg    (r_cfg),
        .o_pop    (pop),
        .o_valid  (bk_valid),
        .o_side   (bk_side),
        .o_lane_u (bk_u),
        .o_lane_v (bk_v)
    );

    ptcg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (bk_valid),
        .i_side   (bk_side),
        .i_lane_u (bk_u),
        .i_lane_v (bk_v),
        .o_valid  (o_valid),
        .o_side   (out_side),
        .o_tex_u  (o_tex_u),
        .o_tex_v  (o_tex_v)
    );

    assign o_plane       = out_side.plane;
    assign o_vertex_slot = out_side.slot;
    assign o_last        = out_side.last;

endmodule

>>> rtl/core/ptcg_front.sv
module ptcg_front (
    input  logic           i_valid,
    output logic           o_stall,
    input  ptcg_pkg::t_vert [2:0] i_vert,
    input  logic [ptcg_pkg::TolW-1:0] i_tol,
    input  logic           i_q_full,
    output logic           o_push,
    output ptcg_pkg::t_tri o_push_tri
);
    import ptcg_pkg::*;

    logic agree_x;
    logic agree_y;
    logic agree_z;

    // Exact 33-bit differences, so no wrap can fake an agreement.
    function automatic logic agree3(t_coord p, t_coord q, t_coord r, logic [TolW-1:0] tol);
        logic signed [CoordW:0] d1;
        logic signed [CoordW:0] d2;
        logic [CoordW:0] m1;
        logic [CoordW:0] m2;
        d1 = {p[CoordW-1], p} - {q[CoordW-1], q};
        d2 = {p[CoordW-1], p} - {r[CoordW-1], r};
        m1 = d1[CoordW] ? (CoordW+1)'(-d1) : (CoordW+1)'(d1);
        m2 = d2[CoordW] ? (CoordW+1)'(-d2) : (CoordW+1)'(d2);
        return (m1 <= (CoordW+1)'(tol)) && (m2 <= (CoordW+1)'(tol));
    endfunction

    always_comb begin
        agree_x = agree3(i_vert[0].x, i_vert[1].x, i_vert[2].x, i_tol);
        agree_y = agree3(i_vert[0].y, i_vert[1].y, i_vert[2].y, i_tol);
        agree_z = agree3(i_vert[0].z, i_vert[1].z, i_vert[2].z, i_tol);
        o_push_tri.vert = i_vert;
        if (agree_x || agree_y) begin
            o_push_tri.plane = (agree_z || agree_y) ? PLANE_XZ : PLANE_YZ;
        end else begin
            o_push_tri.plane = PLANE_XY;
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

>>> rtl/core/ptcg_queue.sv
module ptcg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptcg_pkg::t_tri i_push_tri,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ptcg_pkg::t_tri o_head
);
    import ptcg_pkg::*;

    t_tri       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_tri;
        end
    end

endmodule

>>> rtl/core/ptcg_back.sv
module ptcg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_empty,
    input  ptcg_pkg::t_tri  i_head,
    input  ptcg_pkg::t_cfg  i_cfg,
    output logic            o_pop,
    output logic            o_valid,
    output ptcg_pkg::t_side o_side,
    output ptcg_pkg::t_lane o_lane_u,
    output ptcg_pkg::t_lane o_lane_v
);
    import ptcg_pkg::*;

    logic [1:0] r_slot;
    logic       issue;
    t_vert      vert;
    t_coord     u_val, u_lo, u_hi;
    t_coord     v_val, v_lo, v_hi;

    logic                   r_p1_valid;
    t_side                  r_p1_side;
    logic signed [CoordW:0] r_u_num, r_u_den, r_v_num, r_v_den;

    logic  r_p2_valid;
    t_side r_p2_side;
    t_lane r_lane_u, r_lane_v;

    function automatic logic signed [CoordW:0] sub33(t_coord a, t_coord b);
        return {a[CoordW-1], a} - {b[CoordW-1], b};
    endfunction

    // Sort out the saturated and degenerate cases; what remains is a
    // positive fraction num/den below one for the divider.
    function automatic t_lane prep(logic signed [CoordW:0] num, logic signed [CoordW:0] den);
        t_lane l;
        logic signed [CoordW:0] nneg;
        logic signed [CoordW:0] dneg;
        l = '0;
        nneg = -num;
        dneg = -den;
        if (den == '0) begin
            l.spec = 1'b1;
            l.spec_val = TexHalf;
        end else if (den[CoordW]) begin
            if (!num[CoordW]) begin
                l.spec = 1'b1;
                l.spec_val = TexZero;
            end else if (num <= den) begin
                l.spec = 1'b1;
                l.spec_val = TexOne;
            end else begin
                l.rem = nneg[CoordW-1:0];
                l.den = dneg[CoordW-1:0];
            end
        end else begin
            if (num[CoordW] || num == '0) begin
                l.spec = 1'b1;
                l.spec_val = TexZero;
            end else if (num >= den) begin
                l.spec = 1'b1;
                l.spec_val = TexOne;
            end else begin
                l.rem = num[CoordW-1:0];
                l.den = den[CoordW-1:0];
            end
        end
        return l;
    endfunction

    always_comb begin
        issue = !i_empty && i_en;
        o_pop = issue && (r_slot == 2'd2);
        vert  = i_head.vert[r_slot];
        case (i_head.plane)
            PLANE_YZ: begin
                u_val = vert.z;
                u_lo  = i_cfg.lo[2];
                u_hi  = i_cfg.hi[2];
            end
            default: begin
                u_val = vert.x;
                u_lo  = i_cfg.lo[0];
                u_hi  = i_cfg.hi[0];
            end
        endcase
        case (i_head.plane)
            PLANE_XZ: begin
                v_val = vert.z;
                v_lo  = i_cfg.lo[2];
                v_hi  = i_cfg.hi[2];
            end
            default: begin
                v_val = vert.y;
                v_lo  = i_cfg.lo[1];
                v_hi  = i_cfg.hi[1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= 2'd0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid <= !i_empty;
            r_p2_valid <= r_p1_valid;
            if (issue) begin
                r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_side.plane <= i_head.plane;
            r_p1_side.slot  <= r_slot;
            r_p1_side.last  <= (r_slot == 2'd2);
            r_u_num   <= sub33(u_val, u_lo);
            r_u_den   <= sub33(u_hi, u_lo);
            r_v_num   <= sub33(v_val, v_lo);
            r_v_den   <= sub33(v_hi, v_lo);
            r_p2_side <= r_p1_side;
            r_lane_u  <= prep(r_u_num, r_u_den);
            r_lane_v  <= prep(r_v_num, r_v_den);
        end
    end

    assign o_valid  = r_p2_valid;
    assign o_side   = r_p2_side;
    assign o_lane_u = r_lane_u;
    assign o_lane_v = r_lane_v;

endmodule

>>> rtl/core/ptcg_div.sv
module ptcg_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ptcg_pkg::t_side i_side,
    input  ptcg_pkg::t_lane i_lane_u,
    input  ptcg_pkg::t_lane i_lane_v,
    output logic            o_valid,
    output ptcg_pkg::t_side o_side,
    output logic [ptcg_pkg::TexW-1:0] o_tex_u,
    output logic [ptcg_pkg::TexW-1:0] o_tex_v
);
    import ptcg_pkg::*;

    logic  r_valid [DivSteps];
    t_side r_side  [DivSteps];
    t_lane r_u     [DivSteps];
    t_lane r_v     [DivSteps];

    // One restoring step: shift the remainder and try the divisor.
    function automatic t_lane step(t_lane l);
        t_lane n;
        logic [CoordW:0] rem2;
        logic [CoordW:0] diff;
        n = l;
        rem2 = {l.rem, 1'b0};
        diff = rem2 - {1'b0, l.den};
        if (rem2 >= {1'b0, l.den}) begin
            n.rem = diff[CoordW-1:0];
            n.quo = {l.quo[FracW-2:0], 1'b1};
        end else begin
            n.rem = rem2[CoordW-1:0];
            n.quo = {l.quo[FracW-2:0], 1'b0};
        end
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DivSteps; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < DivSteps; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_u[0]    <= step(i_lane_u);
            r_v[0]    <= step(i_lane_v);
            for (int s = 1; s < DivSteps; s++) begin
                r_side[s] <= r_side[s-1];
                r_u[s]    <= step(r_u[s-1]);
                r_v[s]    <= step(r_v[s-1]);
            end
        end
    end

    assign o_valid = r_valid[DivSteps-1];
    assign o_side  = r_side[DivSteps-1];
    assign o_tex_u = r_u[DivSteps-1].spec ? r_u[DivSteps-1].spec_val
                                          : TexW'(r_u[DivSteps-1].quo);
    assign o_tex_v = r_v[DivSteps-1].spec ? r_v[DivSteps-1].spec_val
                                          : TexW'(r_v[DivSteps-1].quo);

endmodule

>>> test/planar_texture_coord_gen_unit_tb.sv
module planar_texture_coord_gen_unit_tb;
    import ptcg_pkg::*;

    localparam int IdleLimit   = 4000;
    localparam int DrainCycles = 40;
    localparam int RandPerSet  = 70;

    typedef t_coord [0:8] t_tri_flat;

    typedef struct packed {
        t_tri_flat tri_c;
        logic      typed;
        t_plane    plane;
    } t_dir_row;

    typedef struct packed {
        logic [TexW-1:0] u;
        logic [TexW-1:0] v;
        logic [1:0]      plane;
        logic [1:0]      slot;
        logic            last;
    } t_tex_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall;
    logic [16:0] o_tex_u;
    logic [16:0] o_tex_v;
    logic [1:0]  o_plane;
    logic [1:0]  o_vertex_slot;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    t_tri_flat   cur_tri;

    t_tex_res   tex_q[$];
    t_coord     box_lo[3];
    t_coord     box_hi[3];
    logic [15:0] tol_reg;
    int         fail_cnt;
    int         act_cnt;
    int         res_cnt;
    bit         long_hold_done;

    planar_texture_coord_gen_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_a_x(cur_tri[0]), .i_a_y(cur_tri[1]), .i_a_z(cur_tri[2]),
        .i_b_x(cur_tri[3]), .i_b_y(cur_tri[4]), .i_b_z(cur_tri[5]),
        .i_c_x(cur_tri[6]), .i_c_y(cur_tri[7]), .i_c_z(cur_tri[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v), .o_plane(o_plane),
        .o_vertex_slot(o_vertex_slot), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic bit coords_agree(longint p, longint q, longint r, longint tol);
        longint d1;
        longint d2;
        d1 = p - q;
        d2 = p - r;
        if (d1 < 0) d1 = -d1;
        if (d2 < 0) d2 = -d2;
        return (d1 <= tol) && (d2 <= tol);
    endfunction

    function automatic logic [TexW-1:0] norm_coord(longint val, longint lo, longint hi);
        longint num;
        longint den;
        num = val - lo;
        den = hi - lo;
        if (den == 0)
            return TexHalf;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return TexZero;
        if (num >= den)
            return TexOne;
        return TexW'((num * 65536) / den);
    endfunction

    task automatic push_projection(t_tri_flat t);
        bit ax;
        bit ay;
        bit az;
        t_plane pl;
        int ui;
        int vi;
        t_tex_res r;
        ax = coords_agree(t[0], t[3], t[6], tol_reg);
        ay = coords_agree(t[1], t[4], t[7], tol_reg);
        az = coords_agree(t[2], t[5], t[8], tol_reg);
        if (ax || ay) begin
            if (az || ay) begin
                pl = PLANE_XZ; ui = 0; vi = 2;
            end else begin
                pl = PLANE_YZ; ui = 2; vi = 1;
            end
        end else begin
            pl = PLANE_XY; ui = 0; vi = 1;
        end
        for (int k = 0; k < 3; k++) begin
            r.u = norm_coord(t[k*3+ui], box_lo[ui], box_hi[ui]);
            r.v = norm_coord(t[k*3+vi], box_lo[vi], box_hi[vi]);
            r.plane = pl;
            r.slot = 2'(k);
            r.last = (k == 2);
            tex_q = {tex_q, r};
        end
    endtask

    // Called at a falling edge; returns at a falling edge with valid left as the gap wants.
    task automatic send_tri(t_tri_flat t, logic typed, t_plane pl);
        t_tex_res r;
        int g;
        cur_tri = t;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        act_cnt++;
        if (typed) begin
            for (int k = 0; k < 3; k++) begin
                r.u = TexHalf;
                r.v = TexHalf;
                r.plane = pl;
                r.slot = 2'(k);
                r.last = (k == 2);
                tex_q = {tex_q, r};
            end
        end else begin
            push_projection(t);
        end
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        @(negedge i_clk);
        while (tex_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        act_cnt++;
        if (idx < CFG_TOL) begin
            if (idx[0]) box_hi[idx >> 1] = data;
            else        box_lo[idx >> 1] = data;
        end else if (idx == CFG_TOL) begin
            tol_reg = data[15:0];
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_box(t_coord lx, t_coord hx, t_coord ly, t_coord hy,
                             t_coord lz, t_coord hz, logic [31:0] tol);
        write_reg(CFG_MIN_X, lx);
        write_reg(CFG_MAX_X, hx);
        write_reg(CFG_MIN_Y, ly);
        write_reg(CFG_MAX_Y, hy);
        write_reg(CFG_MIN_Z, lz);
        write_reg(CFG_MAX_Z, hz);
        write_reg(CFG_TOL, tol);
    endtask

    function automatic t_tri_flat rand_tri();
        t_tri_flat t;
        int mode;
        t_coord base;
        int span;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            for (int i = 0; i < 9; i++) t[i] = $urandom;
            return t;
        end
        for (int c = 0; c < 3; c++) begin
            if ($urandom_range(0, 4) < 2) begin
                // Near-equal axis: offsets straddle the tolerance.
                base = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
                span = int'(tol_reg) + 2;
                for (int k = 0; k < 3; k++)
                    t[k*3+c] = base + ($urandom_range(0, 1) ?
                               $urandom_range(0, span) : -$urandom_range(0, span));
            end else begin
                for (int k = 0; k < 3; k++)
                    t[k*3+c] = $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
            end
        end
        return t;
    endfunction

    localparam t_coord CMax = 32'sh7fffffff;
    localparam t_coord CMin = 32'sh80000000;

    // First eight rows run against the reset box, where every coordinate is one half.
    t_dir_row dir_tbl [14] = '{
        '{'{1, 2, 3, 100, 200, 300, -5, -9, 70}, 1'b1, PLANE_XY},
        '{'{4, 10, 1, 4, 20, 50, 4, 30, 90}, 1'b1, PLANE_YZ},
        '{'{4, 10, 9, 4, 20, 9, 4, 30, 9}, 1'b1, PLANE_XZ},
        '{'{1, 5, 2, 50, 5, 60, 90, 5, 70}, 1'b1, PLANE_XZ},
        '{'{0, 10, 1, 7, 20, 50, -7, 30, 90}, 1'b1, PLANE_YZ},
        '{'{0, 10, 1, 8, 20, 50, -7, 30, 90}, 1'b1, PLANE_XY},
        '{'{CMax, CMin, 0, CMin, CMax, 0, 0, 0, CMax}, 1'b1, PLANE_XY},
        '{'{CMin, CMin, CMax, CMin, CMin, CMax, CMin, CMin, CMax}, 1'b1, PLANE_XZ},
        '{'{-32'sh00640000, 0, 1, 32'sh00640000, 32'sh00100000, 2, 0, 32'sh8000, 3},
          1'b0, PLANE_XY},
        '{'{-32'sh00650000, -1, 5, 32'sh00650000, 32'sh00110000, 6, 7, 8, 9},
          1'b0, PLANE_XY},
        '{'{3, -1, -32'sh10000, 3, 32'sh00110000, 32'sh500000, 3, 8, 32'sh600000},
          1'b0, PLANE_YZ},
        '{'{CMax, 7, CMin, CMin, 7, CMax, 0, 7, 0}, 1'b0, PLANE_XZ},
        '{'{CMax, CMax, CMax, CMin, CMin, CMin, 1, -1, 1}, 1'b0, PLANE_XY},
        '{'{5, 6, 7, 5, 6, 7, 5, 6, 7}, 1'b0, PLANE_XY}
    };

    // Outputs sampled at the rising edge.
    always @(posedge i_clk) begin
        t_tex_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            act_cnt++;
            res_cnt++;
            if (tex_q.size() == 0) begin
                $error("result with no transaction pending: u=%0d v=%0d", o_tex_u, o_tex_v);
                fail_cnt++;
            end else begin
                e = tex_q.pop_front();
                if (o_tex_u !== e.u) begin
                    $error("tex_u expected %0d actual %0d", e.u, o_tex_u); fail_cnt++;
                end
                if (o_tex_v !== e.v) begin
                    $error("tex_v expected %0d actual %0d", e.v, o_tex_v); fail_cnt++;
                end
                if (o_plane !== e.plane) begin
                    $error("plane expected %0d actual %0d", e.plane, o_plane); fail_cnt++;
                end
                if (o_vertex_slot !== e.slot) begin
                    $error("vertex_slot expected %0d actual %0d", e.slot, o_vertex_slot);
                    fail_cnt++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_last); fail_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off to back up the block.
    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!long_hold_done && res_cnt >= 60) begin
                long_hold_done = 1'b1;
                i_stall = 1'b1;
                repeat (300) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall = 1'b1;
            end else if ((cyc % 400) < 300 && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
                i_stall = (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        int idle;
        int last_act;
        idle = 0;
        last_act = 0;
        while (idle < IdleLimit) begin
            @(negedge i_clk);
            if (act_cnt == last_act) idle++;
            else idle = 0;
            last_act = act_cnt;
        end
        $display("planar_texture_coord_gen_unit verification failed");
        $finish;
    end

    initial begin
        fail_cnt = 0;
        act_cnt = 0;
        res_cnt = 0;
        long_hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_X;
        i_cfg_data = '0;
        cur_tri = '0;
        for (int c = 0; c < 3; c++) begin
            box_lo[c] = '0;
            box_hi[c] = '0;
        end
        tol_reg = TolReset;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 14; i++) begin
            if (i == 8) begin
                wait_idle();
                write_box(-32'sh00640000, 32'sh00640000, 0, 32'sh00100000,
                          -32'sh10000, 32'sh500000, 7);
            end
            send_tri(dir_tbl[i].tri_c, dir_tbl[i].typed, dir_tbl[i].plane);
        end

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        // Widest box and tolerance; upper tolerance bits must be dropped.
                        write_box(CMin, CMax, CMin, CMax, CMin, CMax, 32'hffffffff);
                        write_reg(3'd7, 32'h12345678);
                    end
                    2: write_box(32'sh00100000, -32'sh00100000, 32'sh20000, 32'sh20000,
                                 -32'sh00800000, 32'sh00800000, 0);
                    3: write_box($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    default: write_box(-32'sh00800000, 32'sh00800000, -32'sh00400000,
                                       32'sh00c00000, CMin, 32'sh00010000,
                                       $urandom_range(0, 300));
                endcase
            end
            for (int n = 0; n < RandPerSet; n++)
                send_tri(rand_tri(), 1'b0, PLANE_XY);
        end

        wait_idle();
        if (fail_cnt == 0) begin
            $display("planar_texture_coord_gen_unit verification clean");
        end else begin
            $display("planar_texture_coord_gen_unit verification failed");
        end
        $finish;
    end

endmodule
